>>> rtl/rba_pkg.sv
// ring bump allocator package: item types, function and status codes
// no dependencies; used by ring_bump_allocator
package rba_pkg;

    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 20;
    localparam int ALIGN_W  = 16;
    localparam int OFFSET_W = 21;
    localparam int STATUS_W = 2;
    localparam int WRAPS_W  = 32;
    localparam int PAGES_W  = 9;
    localparam int NEXT_W   = 22;
    localparam int LAST_W   = 21;
    localparam int ALIGN_CLAMP = 4096;
    localparam int LARGE_LIMIT = 4096;
    localparam int PLAIN_GRAIN = 16;
    localparam int PAGES_RESET = 16;
    // narrow width that holds a clamped alignment
    localparam int AL_W = $clog2(ALIGN_CLAMP + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PLAIN = 2'd0,
        FUNC_ALIGN = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_DBL_FREE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SIZE_W-1:0]  alloc_size;
        logic [ALIGN_W-1:0] alignment;
    } req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [STATUS_W-1:0] status;
        logic                wrapped;
        logic [WRAPS_W-1:0]  wrap_count;
    } rsp_t;

endpackage

>>> rtl/ring_bump_allocator.sv
// ring_bump_allocator: bump-pointer allocator over a paged arena
// depends on rba_pkg for item types and codes
//
// One item in, one result out. Plain allocations, frees and the unused
// function code pass through the execute and output states. An aligned
// allocation with non-zero alignment passes through the execute, remainder,
// rounding, placement and output states: the pointer and the size are each
// reduced modulo the alignment by two restoring remainder steps that share
// one divisor, one bit of both per cycle over the full 22-bit pointer and
// size, followed by rounding and the arena fit check. One item is in flight
// at a time; in_ready is high only while the block is idle, so a new item
// is not accepted before the last result is registered, and a result held by
// out_ready low delays the return to idle. The arena size register applies
// to items accepted after the edge that writes it.
module ring_bump_allocator #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rba_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rba_pkg::rsp_t                  out_data,
    input  logic                           cfg_wr_en,
    input  logic [rba_pkg::PAGES_W-1:0]    cfg_wr_data
);

    localparam int ARENA_W = $clog2(MAX_PAGES * PAGE_BYTES + 1);
    localparam int CMP_W   = (ARENA_W > 24) ? ARENA_W : 24;
    localparam int MP_W    = $clog2(MAX_PAGES + 1);
    localparam int PG_W    = (MP_W > rba_pkg::PAGES_W) ? MP_W : rba_pkg::PAGES_W;
    localparam int NW      = rba_pkg::NEXT_W;
    localparam int LW      = rba_pkg::LAST_W;
    localparam int OW      = rba_pkg::OFFSET_W;
    localparam int SW      = rba_pkg::SIZE_W;
    localparam int AW      = rba_pkg::AL_W;
    localparam int POS_W   = NW + 1;
    localparam int CNT_W   = $clog2(NW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_ADJ,
        S_PLACE,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [rba_pkg::FUNC_W-1:0]  func_reg;
    logic [SW-1:0]               size_in_reg;
    logic [AW-1:0]               align_reg;
    logic [rba_pkg::PAGES_W-1:0] pages_reg;
    logic [CMP_W-1:0]            arena_reg;
    logic [NW-1:0]               next_off_reg;
    logic [LW-1:0]               prev_size_reg;
    logic [rba_pkg::WRAPS_W-1:0] wraps_reg;
    logic [NW-1:0]               dvd_a_reg;
    logic [NW-1:0]               dvd_b_reg;
    logic [AW-1:0]               rem_a_reg;
    logic [AW-1:0]               rem_b_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [LW-1:0]               asize_reg;
    rba_pkg::rsp_t               res_reg;
    logic                        out_valid_reg;
    rba_pkg::rsp_t               out_data_reg;

    logic [PG_W-1:0]  pages_ext;
    logic [PG_W-1:0]  pages_eff;
    logic [CMP_W-1:0] arena_next;
    logic [AW-1:0]    align_clamped;
    logic [LW-1:0]    plain_size;
    logic [CMP_W-1:0] plain_sum;
    logic             plain_wrap;
    logic [NW-1:0]    plain_next;
    logic [NW-1:0]    free_next;
    logic [AW:0]      sh_a;
    logic [AW:0]      sh_b;
    logic [AW-1:0]    rem_a_step;
    logic [AW-1:0]    rem_b_step;
    logic [CMP_W-1:0] align_sum;
    logic             is_plain;
    rba_pkg::rsp_t    exec_rsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        pages_ext = PG_W'(pages_reg);
        if (pages_ext == '0)
        begin
            pages_eff = PG_W'(1);
        end
        else if (pages_ext > PG_W'(MAX_PAGES))
        begin
            pages_eff = PG_W'(MAX_PAGES);
        end
        else
        begin
            pages_eff = pages_ext;
        end
        arena_next = CMP_W'(pages_eff) * CMP_W'(PAGE_BYTES);

        if (in_data.alignment > rba_pkg::ALIGN_W'(rba_pkg::ALIGN_CLAMP))
        begin
            align_clamped = AW'(rba_pkg::ALIGN_CLAMP);
        end
        else
        begin
            align_clamped = in_data.alignment[AW-1:0];
        end

        is_plain = (func_reg == rba_pkg::FUNC_PLAIN)
                || ((func_reg == rba_pkg::FUNC_ALIGN) && (align_reg == '0));

        // round up to the plain grain
        plain_size = (LW'(size_in_reg) + LW'(rba_pkg::PLAIN_GRAIN - 1))
                   & ~LW'(rba_pkg::PLAIN_GRAIN - 1);
        plain_sum  = CMP_W'(next_off_reg) + CMP_W'(plain_size);
        plain_wrap = (plain_sum > arena_reg);
        plain_next = plain_wrap ? NW'(plain_size) : plain_sum[NW-1:0];
        free_next  = next_off_reg - NW'(prev_size_reg);

        // result of the functions that finish in the execute state
        exec_rsp            = '0;
        exec_rsp.wrap_count = wraps_reg;
        if (is_plain)
        begin
            if (plain_size > LW'(rba_pkg::LARGE_LIMIT))
            begin
                exec_rsp.status = rba_pkg::ST_TOO_LARGE;
            end
            else if (plain_wrap)
            begin
                exec_rsp.wrapped = 1'b1;
            end
            else
            begin
                exec_rsp.offset = next_off_reg[OW-1:0];
            end
        end
        else if (func_reg == rba_pkg::FUNC_FREE)
        begin
            if (prev_size_reg == '0)
            begin
                exec_rsp.status = rba_pkg::ST_DBL_FREE;
            end
            else
            begin
                exec_rsp.offset = free_next[OW-1:0];
            end
        end

        // remainder steps for the pointer and size lanes, sharing one divisor
        sh_a = {rem_a_reg, dvd_a_reg[NW-1]};
        sh_b = {rem_b_reg, dvd_b_reg[NW-1]};
        if (sh_a >= {1'b0, align_reg})
        begin
            rem_a_step = AW'(sh_a - {1'b0, align_reg});
        end
        else
        begin
            rem_a_step = sh_a[AW-1:0];
        end
        if (sh_b >= {1'b0, align_reg})
        begin
            rem_b_step = AW'(sh_b - {1'b0, align_reg});
        end
        else
        begin
            rem_b_step = sh_b[AW-1:0];
        end

        align_sum = CMP_W'(pos_reg) + CMP_W'(asize_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pages_reg     <= rba_pkg::PAGES_W'(rba_pkg::PAGES_RESET);
            arena_reg     <= CMP_W'(rba_pkg::PAGES_RESET) * CMP_W'(PAGE_BYTES);
            next_off_reg  <= '0;
            prev_size_reg <= '0;
            wraps_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pages_reg <= cfg_wr_data;
            end
            arena_reg <= arena_next;

            if (out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg    <= in_data.func;
                        size_in_reg <= in_data.alloc_size;
                        align_reg   <= align_clamped;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg <= exec_rsp;
                    if (is_plain)
                    begin
                        if (plain_size <= LW'(rba_pkg::LARGE_LIMIT))
                        begin
                            next_off_reg  <= plain_next;
                            prev_size_reg <= plain_size;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (func_reg == rba_pkg::FUNC_ALIGN)
                    begin
                        dvd_a_reg <= next_off_reg;
                        dvd_b_reg <= NW'(size_in_reg);
                        rem_a_reg <= '0;
                        rem_b_reg <= '0;
                        cnt_reg   <= CNT_W'(NW - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if ((func_reg == rba_pkg::FUNC_FREE) && (prev_size_reg != '0))
                        begin
                            next_off_reg  <= free_next;
                            prev_size_reg <= '0;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    rem_a_reg <= rem_a_step;
                    rem_b_reg <= rem_b_step;
                    dvd_a_reg <= {dvd_a_reg[NW-2:0], 1'b0};
                    dvd_b_reg <= {dvd_b_reg[NW-2:0], 1'b0};
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_ADJ;
                    end
                end
                S_ADJ:
                begin
                    if (rem_a_reg != '0)
                    begin
                        pos_reg <= POS_W'(next_off_reg) + POS_W'(align_reg - rem_a_reg);
                    end
                    else
                    begin
                        pos_reg <= POS_W'(next_off_reg);
                    end
                    if (rem_b_reg != '0)
                    begin
                        asize_reg <= LW'(size_in_reg) + LW'(align_reg - rem_b_reg);
                    end
                    else
                    begin
                        asize_reg <= LW'(size_in_reg);
                    end
                    state_reg <= S_PLACE;
                end
                S_PLACE:
                begin
                    prev_size_reg <= asize_reg;
                    if (align_sum > arena_reg)
                    begin
                        wraps_reg          <= wraps_reg + rba_pkg::WRAPS_W'(1);
                        res_reg.wrap_count <= wraps_reg + rba_pkg::WRAPS_W'(1);
                        res_reg.wrapped    <= 1'b1;
                        res_reg.offset     <= '0;
                        next_off_reg       <= NW'(asize_reg);
                    end
                    else
                    begin
                        res_reg.offset <= pos_reg[OW-1:0];
                        next_off_reg   <= align_sum[NW-1:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// testbench for ring_bump_allocator: directed and random allocate/free items
// over valid/ready with varied idling, each result checked against a local predictor
// depends on rba_pkg and the ring_bump_allocator rtl
module tb_top;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_PAGES = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 112;

    class scoreboard_t;
        logic [rba_pkg::PAGES_W-1:0] pages;
        logic [rba_pkg::NEXT_W-1:0] next_off;
        logic [rba_pkg::LAST_W-1:0] prev_size;
        logic [rba_pkg::WRAPS_W-1:0] wraps;
        rba_pkg::rsp_t results_due[$];
        int errors;

        function new();
            pages = rba_pkg::PAGES_W'(rba_pkg::PAGES_RESET);
            next_off = '0;
            prev_size = '0;
            wraps = '0;
            errors = 0;
        endfunction

        function longint unsigned round_to(longint unsigned v, longint unsigned grain);
            if (grain == 0 || v % grain == 0)
                return v;
            return (v / grain + 1) * grain;
        endfunction

        function void note_request(rba_pkg::req_t r);
            longint unsigned arena;
            longint unsigned cur;
            longint unsigned size;
            longint unsigned grain;
            longint unsigned pos;
            rba_pkg::rsp_t rsp;
            arena = (pages == 0) ? 1 : (pages > MAX_PAGES) ? MAX_PAGES : pages;
            arena = arena * PAGE_BYTES;
            cur = next_off;
            rsp = '0;
            if (r.func == rba_pkg::FUNC_PLAIN
                || (r.func == rba_pkg::FUNC_ALIGN && r.alignment == 0))
            begin
                size = round_to(r.alloc_size, rba_pkg::PLAIN_GRAIN);
                if (size > rba_pkg::LARGE_LIMIT)
                    rsp.status = rba_pkg::ST_TOO_LARGE;
                else
                begin
                    // plain path restarts the pointer without counting it
                    if (cur + size > arena)
                    begin
                        cur = 0;
                        rsp.wrapped = 1'b1;
                    end
                    rsp.offset = rba_pkg::OFFSET_W'(cur);
                    next_off = rba_pkg::NEXT_W'(cur + size);
                    prev_size = rba_pkg::LAST_W'(size);
                end
            end
            else if (r.func == rba_pkg::FUNC_ALIGN)
            begin
                grain = (r.alignment > rba_pkg::ALIGN_CLAMP) ? rba_pkg::ALIGN_CLAMP
                                                             : r.alignment;
                pos = round_to(cur, grain);
                size = round_to(r.alloc_size, grain);
                if (pos + size > arena)
                begin
                    wraps = wraps + 1'b1;
                    rsp.wrapped = 1'b1;
                    pos = 0;
                end
                rsp.offset = rba_pkg::OFFSET_W'(pos);
                next_off = rba_pkg::NEXT_W'(pos + size);
                prev_size = rba_pkg::LAST_W'(size);
            end
            else if (r.func == rba_pkg::FUNC_FREE)
            begin
                if (prev_size == 0)
                    rsp.status = rba_pkg::ST_DBL_FREE;
                else
                begin
                    next_off = next_off - rba_pkg::NEXT_W'(prev_size);
                    prev_size = '0;
                    rsp.offset = rba_pkg::OFFSET_W'(next_off);
                end
            end
            rsp.wrap_count = wraps;
            results_due.push_back(rsp);
        endfunction

        function void check_response(rba_pkg::rsp_t got);
            rba_pkg::rsp_t want;
            if (results_due.size() == 0)
            begin
                $error("result with nothing pending: offset %0d status %0d", got.offset,
                       got.status);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.offset !== want.offset)
            begin
                $error("offset: expected %0d, got %0d", want.offset, got.offset);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.wrapped !== want.wrapped)
            begin
                $error("wrapped: expected %0d, got %0d", want.wrapped, got.wrapped);
                errors++;
            end
            if (got.wrap_count !== want.wrap_count)
            begin
                $error("wrap_count: expected %0d, got %0d", want.wrap_count, got.wrap_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    rba_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    rba_pkg::rsp_t out_data;
    logic cfg_wr_en;
    logic [rba_pkg::PAGES_W-1:0] cfg_wr_data;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int cycle_cnt;
    scoreboard_t tracker;

    ring_bump_allocator #(
        .PAGE_BYTES(PAGE_BYTES),
        .MAX_PAGES(MAX_PAGES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tracker.note_request(in_data);
        if (rst_n && out_valid && out_ready)
            tracker.check_response(out_data);
    end

    function automatic rba_pkg::req_t mk(rba_pkg::func_t f, int size, int align);
        rba_pkg::req_t r;
        r.func = f;
        r.alloc_size = rba_pkg::SIZE_W'(size);
        r.alignment = rba_pkg::ALIGN_W'(align);
        return r;
    endfunction

    function automatic rba_pkg::req_t random_request();
        rba_pkg::req_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)
            r.func = rba_pkg::FUNC_PLAIN;
        else if (pick < 75)
            r.func = rba_pkg::FUNC_ALIGN;
        else if (pick < 92)
            r.func = rba_pkg::FUNC_FREE;
        else
            r.func = rba_pkg::FUNC_NOP;
        pick = $urandom_range(99);
        if (pick < 70)
            r.alloc_size = rba_pkg::SIZE_W'($urandom_range(4112));
        else if (pick < 85)
            r.alloc_size = rba_pkg::SIZE_W'($urandom_range(4111, 4065));
        else
            r.alloc_size = rba_pkg::SIZE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 15)
            r.alignment = '0;
        else if (pick < 45)
            r.alignment = rba_pkg::ALIGN_W'($urandom_range(64, 1));
        else if (pick < 70)
            r.alignment = rba_pkg::ALIGN_W'(1 << $urandom_range(12));
        else if (pick < 85)
            r.alignment = rba_pkg::ALIGN_W'($urandom_range(4096, 1));
        else
            r.alignment = rba_pkg::ALIGN_W'($urandom);
        return r;
    endfunction

    task automatic send_item(rba_pkg::req_t r);
        int gap;
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = 0;
        while (gap < 30 && $urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pages(int value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[rba_pkg::PAGES_W-1:0];
        @(posedge clk);
        tracker.pages = value[rba_pkg::PAGES_W-1:0];
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int page_plan[PHASES];
        int snd_plan[4];
        int rcv_plan[4];
        page_plan = '{16, 1, 256, 0, 511, 7, 100, 16};
        snd_plan = '{0, 80, 0, 38};
        rcv_plan = '{0, 0, 80, 38};
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // free with nothing allocated, zero size, size limits
        send_item(mk(rba_pkg::FUNC_FREE, 0, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 0, 0));
        send_item(mk(rba_pkg::FUNC_FREE, 0, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 1, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 4096, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 4097, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 20'hFFFFF, 0));
        send_item(mk(rba_pkg::FUNC_FREE, 0, 0));
        send_item(mk(rba_pkg::FUNC_FREE, 0, 0));
        // aligned path: zero alignment, odd alignment, oversize, clamp
        send_item(mk(rba_pkg::FUNC_ALIGN, 33, 0));
        send_item(mk(rba_pkg::FUNC_ALIGN, 5000, 0));
        send_item(mk(rba_pkg::FUNC_ALIGN, 7, 3));
        send_item(mk(rba_pkg::FUNC_ALIGN, 20'hFFFFF, 1));
        send_item(mk(rba_pkg::FUNC_PLAIN, 16, 0));
        send_item(mk(rba_pkg::FUNC_ALIGN, 100, 4096));
        send_item(mk(rba_pkg::FUNC_ALIGN, 1, 16'hFFFF));
        send_item(mk(rba_pkg::FUNC_ALIGN, 4097, 16'h8000));
        send_item(mk(rba_pkg::FUNC_ALIGN, 20'hFFFFF, 4095));
        send_item(mk(rba_pkg::FUNC_FREE, 0, 0));
        send_item(mk(rba_pkg::FUNC_NOP, 20'hFFFFF, 16'hFFFF));
        send_item(mk(rba_pkg::FUNC_NOP, 0, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 4080, 0));
        send_item(mk(rba_pkg::FUNC_PLAIN, 4081, 0));
        send_item(mk(rba_pkg::FUNC_ALIGN, 0, 4096));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph > 0)
                write_pages(page_plan[ph]);
            snd_idle_pct = snd_plan[ph % 4];
            rcv_stall_pct = rcv_plan[ph % 4];
            repeat (ITEMS_PER_PHASE) send_item(random_request());
        end
        drain();

        if (tracker.errors == 0 && tracker.results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rba_pkg.sv
rtl/ring_bump_allocator.sv
bench/tb_top.sv
